FILE: rtl/core/wtvm_pkg.sv
// Shared constants, command codes and types for the wavetable voice mixer.
// No dependencies; compiled first.
package wtvm_pkg;

  localparam int VOICES       = 16;
  localparam int VOICE_W      = $clog2(VOICES);
  localparam int SAMPLE_WORDS = 65536;
  localparam int SAMPLE_AW    = $clog2(SAMPLE_WORDS);

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_VOLUME = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // Q1.15 unity gain
  localparam logic [15:0] MASTER_UNITY = 16'h8000;

  localparam int ACC_W   = 56;
  localparam int SLOPE_W = 33;
  localparam int DIFF_W  = 34;

  typedef struct packed {
    logic [15:0]               base;
    logic [16:0]               length;
    logic [24:0]               position;
    logic [15:0]               pitch;
    logic                      loops;
    logic [31:0]               gain_l;
    logic [31:0]               gain_r;
    logic signed [SLOPE_W-1:0] slope_l;
    logic signed [SLOPE_W-1:0] slope_r;
    logic [15:0]               goal_l;
    logic [15:0]               goal_r;
    logic [15:0]               count_l;
    logic [15:0]               count_r;
  } voice_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mix_ctl_t;

endpackage

FILE: rtl/core/wtvm_item_if.sv
// Valid/ready channel interfaces for command items and output frames.
// No dependencies.
interface wtvm_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  voice;
  logic [15:0] start_address;
  logic signed [15:0] sample_value;
  logic [16:0] sound_length;
  logic [15:0] volume_left;
  logic [15:0] volume_right;
  logic [15:0] pitch_step;
  logic        loop_flag;
  logic [15:0] fade_samples;

  modport source (output valid, cmd, voice, start_address, sample_value, sound_length,
                  volume_left, volume_right, pitch_step, loop_flag, fade_samples,
                  input ready);
  modport sink (input valid, cmd, voice, start_address, sample_value, sound_length,
                volume_left, volume_right, pitch_step, loop_flag, fade_samples,
                output ready);
endinterface

interface wtvm_frame_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic [15:0]        active_mask;

  modport source (output valid, left_out, right_out, active_mask, input ready);
  modport sink (input valid, left_out, right_out, active_mask, output ready);
endinterface

FILE: rtl/core/wtvm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module wtvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/wtvm_div.sv
// Iterative signed divider for ramp slopes: one quotient bit per cycle.
// Depends on wtvm_pkg.
module wtvm_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [wtvm_pkg::DIFF_W-1:0]   dividend,
  input  logic [15:0]                          divisor,
  output logic                                 done,
  output logic signed [wtvm_pkg::SLOPE_W-1:0]  quot
);
  import wtvm_pkg::*;

  localparam int STEPS = SLOPE_W;

  logic                       busy;
  logic [$clog2(STEPS)-1:0]   cnt;
  logic [15:0]                rem;
  logic [SLOPE_W-1:0]         mq;
  logic                       neg;
  logic [15:0]                dvs;
  logic [DIFF_W-1:0]          mag;
  logic [16:0]                trial;
  logic                       fits;

  assign mag   = dividend[DIFF_W-1] ? DIFF_W'(-dividend) : DIFF_W'(dividend);
  assign trial = {rem, mq[SLOPE_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign quot  = neg ? -$signed(mq) : $signed(mq);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        mq   <= mag[SLOPE_W-1:0];
        neg  <= dividend[DIFF_W-1];
        dvs  <= divisor;
      end else if (busy) begin
        rem <= fits ? 16'(trial - {1'b0, dvs}) : trial[15:0];
        mq  <= {mq[SLOPE_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(STEPS))'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/core/wtvm_mix.sv
// Two-stage multiply pipeline and stereo accumulator with rounding and saturation.
// Depends on wtvm_pkg.
module wtvm_mix (
  input  logic                clk,
  input  logic                rst,
  input  wtvm_pkg::mix_ctl_t  ctl,
  input  logic signed [15:0]  sample,
  input  logic [15:0]         gain_l,
  input  logic [15:0]         gain_r,
  input  logic [15:0]         master,
  output logic                busy,
  output logic signed [15:0]  left,
  output logic signed [15:0]  right
);
  import wtvm_pkg::*;

  logic               v1, v2;
  logic signed [32:0] pl, pr;
  logic signed [49:0] tl, tr;
  logic signed [ACC_W-1:0] acc_l, acc_r;

  function automatic logic signed [15:0] sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0]    s;
    logic signed [ACC_W-31:0]   q;
    s = a + (ACC_W)'(64'sd1 << 29);
    q = (ACC_W-30)'(s >>> 30);
    if (q > (ACC_W-30)'(32767)) return 16'sh7FFF;
    if (q < -(ACC_W-30)'(32768)) return 16'sh8000;
    return q[15:0];
  endfunction

  assign busy  = v1 | v2;
  assign left  = sat(acc_l);
  assign right = sat(acc_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      acc_l <= '0;
      acc_r <= '0;
    end else begin
      v1 <= ctl.valid;
      v2 <= v1;
      if (ctl.clear) begin
        acc_l <= '0;
        acc_r <= '0;
      end else if (v2) begin
        acc_l <= acc_l + ACC_W'(tl);
        acc_r <= acc_r + ACC_W'(tr);
      end
    end
  end

  always_ff @(posedge clk) begin
    pl <= sample * $signed({1'b0, gain_l});
    pr <= sample * $signed({1'b0, gain_r});
    tl <= pl * $signed({1'b0, master});
    tr <= pr * $signed({1'b0, master});
  end
endmodule

FILE: rtl/core/wavetable_voice_mixer.sv
// Wavetable voice mixer top level: command sequencer over voice-state and sample RAMs.
// Depends on wtvm_pkg, wtvm_item_if, wtvm_ram, wtvm_div, wtvm_mix.
//
// Load and start are done as the item is taken. Set volume reads the voice entry and,
// for a ramp, runs the slope dividers. A tick visits the voices one at a time through
// the voice-state RAM: an idle voice is skipped in the scan, and a playing one goes
// through read entry, read sample, update and write back, with a restoring remainder
// step before the write back when a looping voice wraps; then the multiply pipeline
// drains. The frame then waits in an output register, and the next item is taken
// while it waits.
module wavetable_voice_mixer (
  input  logic               clk,
  input  logic               rst,
  wtvm_item_if.sink          in_ch,
  wtvm_frame_if.source       out_ch,
  input  logic               cfg_wen,
  input  logic [15:0]        cfg_wdata
);
  import wtvm_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_VOL_RD  = 4'd1;
  localparam logic [3:0] ST_VOL_DIV = 4'd2;
  localparam logic [3:0] ST_SCAN    = 4'd3;
  localparam logic [3:0] ST_TK_RD   = 4'd4;
  localparam logic [3:0] ST_TK_SMP  = 4'd5;
  localparam logic [3:0] ST_WRAP    = 4'd6;
  localparam logic [3:0] ST_TK_WR   = 4'd7;
  localparam logic [3:0] ST_DRAIN   = 4'd8;
  localparam logic [3:0] ST_FIN     = 4'd9;

  localparam int VW = $bits(voice_t);

  logic [3:0]          state;
  logic [15:0]         master;
  logic [VOICES-1:0]   active, vvalid;
  logic [VOICE_W-1:0]  vi;
  voice_t              ent;
  logic [15:0]         lat_vl, lat_vr, lat_fade;
  logic [3:0]          wk;

  logic                in_fire, voice_ok, last_voice;
  logic                v_we;
  logic [VOICE_W-1:0]  v_waddr, v_raddr;
  voice_t              v_wdata, v_rdata, rd_ent, st_ent, vol_ent, ramp_ent, div_ent, step_ent;
  logic [VW-1:0]       v_rraw;
  logic [SAMPLE_AW-1:0] s_waddr, s_raddr;
  logic                s_we;
  logic [15:0]         s_rdata;

  logic signed [DIFF_W-1:0]  diff_l, diff_r;
  logic signed [SLOPE_W-1:0] quot_l, quot_r;
  logic                div_start, done_l, done_r;

  mix_ctl_t            mix_ctl;
  logic                mix_busy;
  logic signed [15:0]  mix_l, mix_r;

  logic [24:0]         pos_rnd, pos_new, end_pos;
  logic [16:0]         idx;
  logic [33:0]         end_k;
  logic                out_free;

  assign in_fire    = in_ch.valid & in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign voice_ok   = 32'(in_ch.voice) < 32'(VOICES);
  assign last_voice = (vi == VOICE_W'(VOICES - 1));
  assign out_free   = !out_ch.valid || out_ch.ready;

  // entries never written read as the reset value
  assign v_rdata = voice_t'(v_rraw);
  assign rd_ent  = vvalid[vi] ? v_rdata : '0;

  // sample RAM
  assign s_we    = in_fire && (in_ch.cmd == CMD_LOAD);
  assign s_waddr = SAMPLE_AW'(in_ch.start_address);

  always_comb begin
    pos_rnd = rd_ent.position + 25'd128;
    idx     = pos_rnd[24:8];
    if (idx >= rd_ent.length) idx = rd_ent.length - 17'd1;
    s_raddr = SAMPLE_AW'(rd_ent.base + idx[15:0]);
  end

  wtvm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_samples (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(in_ch.sample_value),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // start entry
  always_comb begin
    st_ent          = '0;
    st_ent.base     = in_ch.start_address;
    st_ent.length   = in_ch.sound_length;
    st_ent.pitch    = in_ch.pitch_step;
    st_ent.loops    = in_ch.loop_flag;
    st_ent.gain_l   = {in_ch.volume_left, 16'h0};
    st_ent.gain_r   = {in_ch.volume_right, 16'h0};
    st_ent.goal_l   = in_ch.volume_left;
    st_ent.goal_r   = in_ch.volume_right;
  end

  // set volume at once
  always_comb begin
    vol_ent         = rd_ent;
    vol_ent.gain_l  = {lat_vl, 16'h0};
    vol_ent.gain_r  = {lat_vr, 16'h0};
    vol_ent.slope_l = '0;
    vol_ent.slope_r = '0;
    vol_ent.goal_l  = lat_vl;
    vol_ent.goal_r  = lat_vr;
    vol_ent.count_l = '0;
    vol_ent.count_r = '0;
  end

  // ramp setup: gain stays, slopes arrive from the dividers
  always_comb begin
    ramp_ent         = rd_ent;
    ramp_ent.goal_l  = lat_vl;
    ramp_ent.goal_r  = lat_vr;
    ramp_ent.count_l = lat_fade;
    ramp_ent.count_r = lat_fade;
  end

  always_comb begin
    div_ent         = ent;
    div_ent.slope_l = quot_l;
    div_ent.slope_r = quot_r;
  end

  assign diff_l    = $signed({2'b0, lat_vl, 16'h0}) - $signed({2'b0, rd_ent.gain_l});
  assign diff_r    = $signed({2'b0, lat_vr, 16'h0}) - $signed({2'b0, rd_ent.gain_r});
  assign div_start = (state == ST_VOL_RD) && (lat_fade != 16'h0);

  wtvm_div u_div_l (
    .clk(clk), .rst(rst), .start(div_start), .dividend(diff_l), .divisor(lat_fade),
    .done(done_l), .quot(quot_l)
  );
  wtvm_div u_div_r (
    .clk(clk), .rst(rst), .start(div_start), .dividend(diff_r), .divisor(lat_fade),
    .done(done_r), .quot(quot_r)
  );

  // per-tick ramp and position step
  always_comb begin
    step_ent = ent;
    if (ent.count_l != 16'h0) begin
      step_ent.count_l = ent.count_l - 16'd1;
      step_ent.gain_l  = (ent.count_l == 16'd1) ? {ent.goal_l, 16'h0}
                                                : ent.gain_l + ent.slope_l[31:0];
    end
    if (ent.count_r != 16'h0) begin
      step_ent.count_r = ent.count_r - 16'd1;
      step_ent.gain_r  = (ent.count_r == 16'd1) ? {ent.goal_r, 16'h0}
                                                : ent.gain_r + ent.slope_r[31:0];
    end
    pos_new           = ent.position + {9'h0, ent.pitch};
    step_ent.position = pos_new;
  end

  assign end_pos = {ent.length, 8'h0};
  assign end_k   = 34'(end_pos) << wk;

  // voice-state RAM write port
  always_comb begin
    v_we    = 1'b0;
    v_waddr = vi;
    v_wdata = ent;
    unique case (state)
      ST_IDLE: begin
        v_we    = in_fire && (in_ch.cmd == CMD_START) && voice_ok;
        v_waddr = VOICE_W'(in_ch.voice);
        v_wdata = st_ent;
      end
      ST_VOL_RD: begin
        v_we    = (lat_fade == 16'h0);
        v_wdata = vol_ent;
      end
      ST_VOL_DIV: begin
        v_we    = done_l;
        v_wdata = div_ent;
      end
      ST_TK_WR: v_we = 1'b1;
      default: v_we = 1'b0;
    endcase
  end

  assign v_raddr = (state == ST_IDLE) ? VOICE_W'(in_ch.voice) : vi;

  wtvm_ram #(.WIDTH(VW), .DEPTH(VOICES)) u_voices (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rraw)
  );

  assign mix_ctl.clear = in_fire && (in_ch.cmd == CMD_TICK);
  assign mix_ctl.valid = (state == ST_TK_SMP);

  wtvm_mix u_mix (
    .clk(clk), .rst(rst), .ctl(mix_ctl), .sample(s_rdata),
    .gain_l(ent.gain_l[31:16]), .gain_r(ent.gain_r[31:16]), .master(master),
    .busy(mix_busy), .left(mix_l), .right(mix_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      master <= MASTER_UNITY;
      active <= '0;
      vvalid <= '0;
      vi     <= '0;
      wk     <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_wen) master <= cfg_wdata;
      if (v_we) vvalid[v_waddr] <= 1'b1;
      if (state == ST_FIN && out_free) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (in_ch.cmd)
              CMD_START: begin
                if (voice_ok) active[VOICE_W'(in_ch.voice)] <= (in_ch.sound_length != 17'h0);
              end
              CMD_VOLUME: begin
                if (voice_ok) begin
                  vi    <= VOICE_W'(in_ch.voice);
                  state <= ST_VOL_RD;
                end
              end
              CMD_TICK: begin
                vi    <= '0;
                state <= ST_SCAN;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_VOL_RD: begin
          ent   <= ramp_ent;
          state <= (lat_fade == 16'h0) ? ST_IDLE : ST_VOL_DIV;
        end
        ST_VOL_DIV: begin
          if (done_l) state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (active[vi]) begin
            state <= ST_TK_RD;
          end else if (last_voice) begin
            state <= ST_DRAIN;
          end else begin
            vi <= vi + 1'b1;
          end
        end
        ST_TK_RD: begin
          ent   <= rd_ent;
          state <= ST_TK_SMP;
        end
        ST_TK_SMP: begin
          ent   <= step_ent;
          state <= ST_TK_WR;
          if (pos_new >= end_pos) begin
            if (ent.loops) begin
              wk    <= 4'd8;
              state <= ST_WRAP;
            end else begin
              active[vi] <= 1'b0;
            end
          end
        end
        ST_WRAP: begin
          // restoring remainder, one shifted multiple of the end per cycle
          if (34'(ent.position) >= end_k) ent.position <= 25'(34'(ent.position) - end_k);
          if (wk == 4'd0) state <= ST_TK_WR;
          else wk <= wk - 4'd1;
        end
        ST_TK_WR: begin
          if (last_voice) begin
            state <= ST_DRAIN;
          end else begin
            vi    <= vi + 1'b1;
            state <= ST_SCAN;
          end
        end
        ST_DRAIN: begin
          if (!mix_busy) state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_ch.left_out    <= mix_l;
            out_ch.right_out   <= mix_r;
            out_ch.active_mask <= 16'(active);
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lat_vl   <= in_ch.volume_left;
      lat_vr   <= in_ch.volume_right;
      lat_fade <= in_ch.fade_samples;
    end
  end

`ifndef NO_ASSERTIONS
  a_frame_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == ST_FIN)
    else $error("frame raised outside the finish step");

  a_mix_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mix_busy)
    else $error("multiply pipeline busy while idle");

  a_active_written: assert property (@(posedge clk) disable iff (rst)
    (active & ~vvalid) == '0)
    else $error("voice playing from an entry never written");

  a_div_in_ramp: assert property (@(posedge clk) disable iff (rst)
    done_l |-> state == ST_VOL_DIV && done_r)
    else $error("slope dividers out of step");
`endif
endmodule
